[rtl/dqr_pkg.sv]
package dqr_pkg;

    localparam int DEPTH_DEF       = 16;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int REQ_W           = 2;
    localparam int ITEM_W          = 32;
    localparam int COUNT_OUT_W     = 5;

    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_REMOVE     = 2'd2;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_APPLY
    } t_state;

    typedef enum logic [1:0] {
        SEL_HOLD,
        SEL_PREV,
        SEL_NEXT,
        SEL_LOAD
    } t_cell_sel;

    typedef struct packed {
        t_cell_sel sel;
        logic      capture;
    } t_cell_ctl;

endpackage

[rtl/deque_with_remove_by_value_top.sv]
// Double-ended queue of up to DEPTH words held in a row of cells, front in
// cell 0. A request is accepted only while the block is idle and passes
// through capture, a parallel compare of the key against every cell, and an
// update in which each cell loads, holds or takes its neighbour's word. One
// result word leaves per request through an output register; the update
// step waits while the previous result is still unread, and no new request
// is taken until the update of the one before it is done.
// The first-match search for remove is a log2(DEPTH) level prefix OR.
module deque_with_remove_by_value_top #(
    parameter int DEPTH       = dqr_pkg::DEPTH_DEF,
    parameter int VALUE_WIDTH = dqr_pkg::VALUE_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [dqr_pkg::REQ_W-1:0]       i_req_type,
    input  logic [dqr_pkg::ITEM_W-1:0]      i_item_value,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic                            o_accepted,
    output logic [dqr_pkg::ITEM_W-1:0]      o_item_out,
    output logic [dqr_pkg::COUNT_OUT_W-1:0] o_entry_count,
    output logic                            o_queue_empty,
    output logic [dqr_pkg::ITEM_W-1:0]      o_front_item
);

    localparam int CW  = $clog2(DEPTH + 1);
    localparam int LVL = $clog2(DEPTH);

    dqr_pkg::t_state r_state, n_state;

    logic [dqr_pkg::REQ_W-1:0]       r_req;
    logic [VALUE_WIDTH-1:0]          r_key;
    logic [CW-1:0]                   r_count, n_count;
    logic                            r_out_valid, n_out_valid;
    logic                            r_accepted;
    logic [dqr_pkg::ITEM_W-1:0]      r_item_out;
    logic [dqr_pkg::COUNT_OUT_W-1:0] r_entry_count;
    logic                            r_queue_empty;
    logic [dqr_pkg::ITEM_W-1:0]      r_front_item;

    logic w_take;
    logic w_do_match;
    logic w_apply;
    logic w_out_free;
    logic w_ok;
    logic w_full;
    logic w_empty;

    logic [VALUE_WIDTH-1:0] w_value      [DEPTH];
    logic [VALUE_WIDTH-1:0] w_value_next [DEPTH];
    logic [VALUE_WIDTH-1:0] w_prev       [DEPTH];
    logic [VALUE_WIDTH-1:0] w_next       [DEPTH];
    logic [DEPTH-1:0]       w_match;
    logic [DEPTH-1:0]       w_pre        [LVL+1];
    dqr_pkg::t_cell_ctl     w_ctl        [DEPTH];

    // cell row
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign w_prev[g] = r_key;
        end else begin : g_mid_prev
            assign w_prev[g] = w_value[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_next[g] = w_value[g];
        end else begin : g_mid_next
            assign w_next[g] = w_value[g+1];
        end

        dqr_cell #(
            .VALUE_WIDTH (VALUE_WIDTH)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl[g]),
            .i_key        (r_key),
            .i_prev       (w_prev[g]),
            .i_next       (w_next[g]),
            .o_value      (w_value[g]),
            .o_value_next (w_value_next[g]),
            .o_match      (w_match[g])
        );
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            dqr_pkg::ST_IDLE:  if (i_valid) n_state = dqr_pkg::ST_MATCH;
            dqr_pkg::ST_MATCH: n_state = dqr_pkg::ST_APPLY;
            dqr_pkg::ST_APPLY: if (w_out_free) n_state = dqr_pkg::ST_IDLE;
            default:           n_state = dqr_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_ready    = 1'b0;
        w_do_match = 1'b0;
        w_apply    = 1'b0;
        case (r_state)
            dqr_pkg::ST_IDLE:  o_ready    = 1'b1;
            dqr_pkg::ST_MATCH: w_do_match = 1'b1;
            dqr_pkg::ST_APPLY: w_apply    = w_out_free;
            default: ;
        endcase
    end

    assign w_take     = i_valid && o_ready;
    assign w_out_free = !r_out_valid || i_ready;
    assign w_full     = (r_count == CW'(DEPTH));
    assign w_empty    = (r_count == '0);

    // first live match and everything behind it
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            w_pre[0][i] = w_match[i] && (CW'(i) < r_count);
        end
        for (int l = 0; l < LVL; l++) begin
            for (int i = 0; i < DEPTH; i++) begin
                if (i >= (1 << l)) begin
                    w_pre[l+1][i] = w_pre[l][i] | w_pre[l][i-(1<<l)];
                end else begin
                    w_pre[l+1][i] = w_pre[l][i];
                end
            end
        end
    end

    always_comb begin
        case (r_req)
            dqr_pkg::REQ_PUSH_FRONT: w_ok = !w_full;
            dqr_pkg::REQ_PUSH_BACK:  w_ok = !w_full;
            dqr_pkg::REQ_REMOVE:     w_ok = w_pre[LVL][DEPTH-1];
            default:                 w_ok = !w_empty;
        endcase
    end

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            w_ctl[i].capture = w_do_match;
            w_ctl[i].sel     = dqr_pkg::SEL_HOLD;
            if (w_apply && w_ok) begin
                case (r_req)
                    dqr_pkg::REQ_PUSH_FRONT: w_ctl[i].sel = dqr_pkg::SEL_PREV;
                    dqr_pkg::REQ_PUSH_BACK: begin
                        if (CW'(i) == r_count) w_ctl[i].sel = dqr_pkg::SEL_LOAD;
                    end
                    dqr_pkg::REQ_REMOVE: begin
                        if (w_pre[LVL][i]) w_ctl[i].sel = dqr_pkg::SEL_NEXT;
                    end
                    default: w_ctl[i].sel = dqr_pkg::SEL_NEXT;
                endcase
            end
        end
    end

    always_comb begin
        n_count = r_count;
        if (w_apply && w_ok) begin
            if (r_req == dqr_pkg::REQ_PUSH_FRONT || r_req == dqr_pkg::REQ_PUSH_BACK) begin
                n_count = r_count + 1'b1;
            end else begin
                n_count = r_count - 1'b1;
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_apply) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dqr_pkg::ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_req <= i_req_type;
            r_key <= VALUE_WIDTH'(i_item_value);
        end
        if (w_apply) begin
            r_accepted    <= w_ok;
            r_item_out    <= (r_req == dqr_pkg::REQ_POP_FRONT && w_ok) ?
                             dqr_pkg::ITEM_W'(w_value[0]) : '0;
            r_entry_count <= dqr_pkg::COUNT_OUT_W'(n_count);
            r_queue_empty <= (n_count == '0);
            r_front_item  <= (n_count != '0) ? dqr_pkg::ITEM_W'(w_value_next[0]) : '0;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_accepted    = r_accepted;
    assign o_item_out    = r_item_out;
    assign o_entry_count = r_entry_count;
    assign o_queue_empty = r_queue_empty;
    assign o_front_item  = r_front_item;

endmodule

[rtl/dqr_cell.sv]
module dqr_cell #(
    parameter int VALUE_WIDTH = dqr_pkg::VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  dqr_pkg::t_cell_ctl     i_ctl,
    input  logic [VALUE_WIDTH-1:0] i_key,
    input  logic [VALUE_WIDTH-1:0] i_prev,
    input  logic [VALUE_WIDTH-1:0] i_next,
    output logic [VALUE_WIDTH-1:0] o_value,
    output logic [VALUE_WIDTH-1:0] o_value_next,
    output logic                   o_match
);

    logic [VALUE_WIDTH-1:0] r_value;
    logic                   r_match;

    always_comb begin
        case (i_ctl.sel)
            dqr_pkg::SEL_PREV: o_value_next = i_prev;
            dqr_pkg::SEL_NEXT: o_value_next = i_next;
            dqr_pkg::SEL_LOAD: o_value_next = i_key;
            default:           o_value_next = r_value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= o_value_next;
        if (i_ctl.capture) begin
            r_match <= (r_value == i_key);
        end
    end

    assign o_value = r_value;
    assign o_match = r_match;

endmodule

[rtl/dqr_checker.sv]
module dqr_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_valid,
    input logic                            i_ready,
    input logic                            o_accepted,
    input logic [dqr_pkg::ITEM_W-1:0]      o_item_out,
    input logic [dqr_pkg::COUNT_OUT_W-1:0] o_entry_count,
    input logic                            o_queue_empty,
    input logic [dqr_pkg::ITEM_W-1:0]      o_front_item
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_item_out) && $stable(o_entry_count))
        else $error("result word changed while stalled");

    a_empty_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_queue_empty |-> o_front_item == '0 && o_entry_count == '0)
        else $error("empty queue reports a front word or a count");

    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_accepted |-> o_item_out == '0)
        else $error("refused request returned a popped word");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item_out != '0 |-> o_accepted)
        else $error("popped word without acceptance");

endmodule

bind deque_with_remove_by_value_top dqr_checker u_dqr_checker (.*);

[tb/deque_checker.sv]
`timescale 1ns / 1ps

module deque_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_req_valid,
    input  logic                            i_req_ready,
    input  logic [dqr_pkg::REQ_W-1:0]       i_req_type,
    input  logic [dqr_pkg::ITEM_W-1:0]      i_item_value,
    input  logic                            i_res_valid,
    input  logic                            i_res_ready,
    input  logic                            i_accepted,
    input  logic [dqr_pkg::ITEM_W-1:0]      i_item_out,
    input  logic [dqr_pkg::COUNT_OUT_W-1:0] i_entry_count,
    input  logic                            i_queue_empty,
    input  logic [dqr_pkg::ITEM_W-1:0]      i_front_item,
    output int                              o_fail_count
);

    typedef struct packed {
        logic                            accepted;
        logic [dqr_pkg::ITEM_W-1:0]      item_out;
        logic [dqr_pkg::COUNT_OUT_W-1:0] entry_count;
        logic                            queue_empty;
        logic [dqr_pkg::ITEM_W-1:0]      front_item;
    } t_deque_result;

    logic [dqr_pkg::ITEM_W-1:0] shadow_slots [dqr_pkg::DEPTH_DEF];
    int                         shadow_count;
    t_deque_result              due_results [$];
    int                         mismatches;
    int                         waiting;

    assign o_fail_count = mismatches + waiting;

    // drop the entry at pos and close the gap towards the front
    function automatic void close_gap(input int pos);
        for (int k = pos; k + 1 < shadow_count; k++) begin
            shadow_slots[k] = shadow_slots[k + 1];
        end
        shadow_count--;
    endfunction

    function automatic t_deque_result serve_request(
        input logic [dqr_pkg::REQ_W-1:0]  req,
        input logic [dqr_pkg::ITEM_W-1:0] value
    );
        t_deque_result res;
        res = '0;
        case (req)
            dqr_pkg::REQ_PUSH_FRONT: begin
                if (shadow_count < dqr_pkg::DEPTH_DEF) begin
                    for (int k = shadow_count; k > 0; k--) begin
                        shadow_slots[k] = shadow_slots[k - 1];
                    end
                    shadow_slots[0] = value;
                    shadow_count++;
                    res.accepted = 1'b1;
                end
            end
            dqr_pkg::REQ_PUSH_BACK: begin
                if (shadow_count < dqr_pkg::DEPTH_DEF) begin
                    shadow_slots[shadow_count] = value;
                    shadow_count++;
                    res.accepted = 1'b1;
                end
            end
            dqr_pkg::REQ_REMOVE: begin
                for (int k = 0; k < shadow_count; k++) begin
                    if (!res.accepted && shadow_slots[k] == value) begin
                        close_gap(k);
                        res.accepted = 1'b1;
                    end
                end
            end
            default: begin
                if (shadow_count > 0) begin
                    res.item_out = shadow_slots[0];
                    close_gap(0);
                    res.accepted = 1'b1;
                end
            end
        endcase
        res.entry_count = dqr_pkg::COUNT_OUT_W'(shadow_count);
        res.queue_empty = (shadow_count == 0);
        res.front_item  = (shadow_count > 0) ? shadow_slots[0] : '0;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_deque_result got;
        t_deque_result want;
        if (!i_rst_n) begin
            shadow_count = 0;
            due_results.delete();
            mismatches = 0;
            waiting    = 0;
        end else begin
            if (i_req_valid && i_req_ready) begin
                due_results.push_back(serve_request(i_req_type, i_item_value));
            end
            if (i_res_valid && i_res_ready) begin
                got = {i_accepted, i_item_out, i_entry_count, i_queue_empty, i_front_item};
                if (due_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: result word with nothing expected: %p", $time, got);
                    end
                end else begin
                    want = due_results.pop_front();
                    if (got.accepted !== want.accepted || got.item_out !== want.item_out ||
                        got.entry_count !== want.entry_count ||
                        got.queue_empty !== want.queue_empty ||
                        got.front_item !== want.front_item) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: mismatch expected %p actual %p", $time, want, got);
                        end
                    end
                end
            end
            waiting = due_results.size();
        end
    end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 1080;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_valid = 1'b0;
    logic                            o_ready;
    logic [dqr_pkg::REQ_W-1:0]       i_req_type = dqr_pkg::REQ_PUSH_FRONT;
    logic [dqr_pkg::ITEM_W-1:0]      i_item_value = '0;
    logic                            o_valid;
    logic                            i_ready = 1'b0;
    logic                            o_accepted;
    logic [dqr_pkg::ITEM_W-1:0]      o_item_out;
    logic [dqr_pkg::COUNT_OUT_W-1:0] o_entry_count;
    logic                            o_queue_empty;
    logic [dqr_pkg::ITEM_W-1:0]      o_front_item;

    int fail_count;
    int words_in = 0;
    int words_out = 0;
    int cycles = 0;
    int stall_left = 0;
    bit calm = 1'b0;

    always #10 i_clk = ~i_clk;

    deque_with_remove_by_value_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_req_type   (i_req_type),
        .i_item_value (i_item_value),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_accepted   (o_accepted),
        .o_item_out   (o_item_out),
        .o_entry_count(o_entry_count),
        .o_queue_empty(o_queue_empty),
        .o_front_item (o_front_item)
    );

    deque_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_valid),
        .i_req_ready  (o_ready),
        .i_req_type   (i_req_type),
        .i_item_value (i_item_value),
        .i_res_valid  (o_valid),
        .i_res_ready  (i_ready),
        .i_accepted   (o_accepted),
        .i_item_out   (o_item_out),
        .i_entry_count(o_entry_count),
        .i_queue_empty(o_queue_empty),
        .i_front_item (o_front_item),
        .o_fail_count (fail_count)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("deque_with_remove_by_value_top verification failed");
            $finish;
        end
    end

    // result side: random stalls, none while calm
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            stall_left <= 0;
        end else begin
            if (o_valid && i_ready) begin
                words_out <= words_out + 1;
            end
            if (stall_left > 0) begin
                i_ready <= 1'b0;
                stall_left <= stall_left - 1;
            end else begin
                i_ready <= 1'b1;
                if (!calm && $urandom_range(0, 3) == 0) begin
                    stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                              : $urandom_range(1, 3);
                end
            end
        end
    end

    task automatic send_word(input logic [dqr_pkg::REQ_W-1:0] req,
                             input logic [dqr_pkg::ITEM_W-1:0] value);
        i_valid <= 1'b1;
        i_req_type <= req;
        i_item_value <= value;
        do @(posedge i_clk); while (!o_ready);
        words_in++;
    endtask

    task automatic hold_off();
        int gap;
        gap = calm ? 0 : (($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                       : $urandom_range(0, 2));
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        wait (words_out == words_in);
        @(posedge i_clk);
    endtask

    // small pool so removes find matches and duplicates build up
    function automatic logic [dqr_pkg::ITEM_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return dqr_pkg::ITEM_W'($urandom_range(1, 6));
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [dqr_pkg::REQ_W-1:0] pick_request(input int bias);
        int roll;
        roll = $urandom_range(0, 99);
        if (bias == 0) begin
            if (roll < 80) begin
                return (roll < 40) ? dqr_pkg::REQ_PUSH_FRONT : dqr_pkg::REQ_PUSH_BACK;
            end
            return (roll < 90) ? dqr_pkg::REQ_REMOVE : dqr_pkg::REQ_POP_FRONT;
        end
        if (bias == 1) begin
            if (roll < 80) begin
                return (roll < 40) ? dqr_pkg::REQ_REMOVE : dqr_pkg::REQ_POP_FRONT;
            end
            return (roll < 90) ? dqr_pkg::REQ_PUSH_FRONT : dqr_pkg::REQ_PUSH_BACK;
        end
        return dqr_pkg::REQ_W'($urandom_range(0, 3));
    endfunction

    initial begin
        int sent;
        int phase_len;
        int bias;
        int phase_no;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed opening
        send_word(dqr_pkg::REQ_POP_FRONT, 32'h0000_0000);
        send_word(dqr_pkg::REQ_REMOVE, 32'h0000_0000);
        send_word(dqr_pkg::REQ_PUSH_BACK, 32'h0000_0000);
        send_word(dqr_pkg::REQ_PUSH_BACK, 32'hFFFF_FFFF);
        send_word(dqr_pkg::REQ_PUSH_FRONT, 32'hA5A5_A5A5);
        send_word(dqr_pkg::REQ_PUSH_BACK, 32'hA5A5_A5A5);
        hold_off();
        send_word(dqr_pkg::REQ_REMOVE, 32'hA5A5_A5A5);
        send_word(dqr_pkg::REQ_REMOVE, 32'h1234_5678);
        send_word(dqr_pkg::REQ_REMOVE, 32'hFFFF_FFFF);
        send_word(dqr_pkg::REQ_PUSH_FRONT, 32'h5A5A_5A5A);
        send_word(dqr_pkg::REQ_POP_FRONT, 32'h0000_0000);
        send_word(dqr_pkg::REQ_POP_FRONT, 32'hFFFF_FFFF);
        send_word(dqr_pkg::REQ_POP_FRONT, 32'h0000_0000);
        send_word(dqr_pkg::REQ_POP_FRONT, 32'h0000_0000);
        send_word(dqr_pkg::REQ_REMOVE, 32'hA5A5_A5A5);
        for (int k = 0; k < 9; k++) begin
            send_word((k % 2) ? dqr_pkg::REQ_PUSH_BACK : dqr_pkg::REQ_PUSH_FRONT,
                      dqr_pkg::ITEM_W'(k % 3));
        end
        drain_results();

        // random phases: fill, drain or mixed
        sent = 0;
        phase_no = 0;
        while (sent < RANDOM_ITEMS) begin
            phase_len = $urandom_range(20, 60);
            bias = $urandom_range(0, 2);
            calm = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
                send_word(pick_request(bias), pick_value());
                sent++;
                hold_off();
            end
            phase_no++;
            if (phase_no % 5 == 0) begin
                drain_results();
            end
        end
        calm = 1'b0;

        drain_results();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("deque_with_remove_by_value_top verification clean");
        end else begin
            $display("deque_with_remove_by_value_top verification failed");
        end
        $finish;
    end

endmodule
